[hw/rtl/npcm_pkg.sv]
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, the fixed 16-entry palette and the integer square root step
// used by the nearest palette color match pipeline.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int ChanW        = 8;
  localparam int IdxW         = 4;
  localparam int PalSize      = 16;
  localparam int SqW          = 18;
  localparam int RootW        = SqW / 2;
  localparam int RemW         = RootW + 3;
  localparam int StepsPerStage = 3;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [RootW-1:0] root_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef struct packed {
    logic [SqW-1:0]  v;
    logic [RemW-1:0] rem;
    root_t           root;
  } sqrt_t;

  function automatic rgb_t pal_color(input idx_t idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd0,   8'd0,   8'd178};
      4'd2:    c = '{8'd0,   8'd178, 8'd0};
      4'd3:    c = '{8'd0,   8'd178, 8'd178};
      4'd4:    c = '{8'd178, 8'd0,   8'd0};
      4'd5:    c = '{8'd255, 8'd127, 8'd255};
      4'd6:    c = '{8'd204, 8'd153, 8'd102};
      4'd7:    c = '{8'd127, 8'd127, 8'd127};
      4'd8:    c = '{8'd0,   8'd0,   8'd0};
      4'd9:    c = '{8'd102, 8'd102, 8'd255};
      4'd10:   c = '{8'd102, 8'd255, 8'd102};
      4'd11:   c = '{8'd0,   8'd255, 8'd100};
      4'd12:   c = '{8'd255, 8'd102, 8'd102};
      4'd13:   c = '{8'd255, 8'd204, 8'd255};
      4'd14:   c = '{8'd255, 8'd255, 8'd0};
      4'd15:   c = '{8'd255, 8'd255, 8'd255};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

  // one root bit per step, two radicand bits shifted in
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t           o;
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    rem2  = {s.rem[RemW-3:0], s.v[SqW-1:SqW-2]};
    trial = {{(RemW-RootW-2){1'b0}}, s.root, 2'b01};
    o.v   = {s.v[SqW-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_stage(input sqrt_t s);
    sqrt_t t;
    t = s;
    for (int k = 0; k < StepsPerStage; k++) begin
      t = sqrt_step(t);
    end
    return t;
  endfunction

endpackage

[hw/rtl/npcm_lane.sv]
// ----------------------------------------------------------------------------
// npcm_lane
// Distance from the pixel to one palette color: absolute differences,
// sum of squares, then a three-stage truncated square root.
// ----------------------------------------------------------------------------
module npcm_lane (
  input  logic            clk,
  input  npcm_pkg::chan_t px_red,
  input  npcm_pkg::chan_t px_green,
  input  npcm_pkg::chan_t px_blue,
  input  npcm_pkg::rgb_t  pal,
  output npcm_pkg::root_t dist_root
);

  npcm_pkg::chan_t dr_r, dg_r, db_r;
  logic [2*npcm_pkg::ChanW-1:0] dr_sq, dg_sq, db_sq;
  logic [npcm_pkg::SqW-1:0] sq_r;
  npcm_pkg::sqrt_t st1_r, st2_r, st3_r;
  npcm_pkg::sqrt_t st0;

  function automatic npcm_pkg::chan_t absdiff(input npcm_pkg::chan_t a,
                                              input npcm_pkg::chan_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  always_comb begin
    dr_sq    = {{npcm_pkg::ChanW{1'b0}}, dr_r} * {{npcm_pkg::ChanW{1'b0}}, dr_r};
    dg_sq    = {{npcm_pkg::ChanW{1'b0}}, dg_r} * {{npcm_pkg::ChanW{1'b0}}, dg_r};
    db_sq    = {{npcm_pkg::ChanW{1'b0}}, db_r} * {{npcm_pkg::ChanW{1'b0}}, db_r};
    st0.v    = sq_r;
    st0.rem  = '0;
    st0.root = '0;
  end

  always_ff @(posedge clk) begin
    dr_r  <= absdiff(pal.r, px_red);
    dg_r  <= absdiff(pal.g, px_green);
    db_r  <= absdiff(pal.b, px_blue);
    sq_r  <= {2'b00, dr_sq} + {2'b00, dg_sq} + {2'b00, db_sq};
    st1_r <= npcm_pkg::sqrt_stage(st0);
    st2_r <= npcm_pkg::sqrt_stage(st1_r);
    st3_r <= npcm_pkg::sqrt_stage(st2_r);
  end

  assign dist_root = st3_r.root;

endmodule

[hw/rtl/nearest_palette_color_match_core.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core
// Index of the nearest of sixteen fixed palette colors to an RGB pixel,
// by truncated Euclidean distance.
//
//   channel  ports                                   handshake
//   input    in_red, in_green, in_blue               start & !busy
//   result   out_palette_index                       out_valid, one cycle
//
// One pixel is taken every cycle; busy is always low.
// A result passes through the sixteen distance lanes (five stages) and the
// two-stage minimum tree. Synchronous reset clears only the valid bits;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  npcm_pkg::chan_t in_red,
  input  npcm_pkg::chan_t in_green,
  input  npcm_pkg::chan_t in_blue,
  output logic            out_valid,
  output npcm_pkg::idx_t  out_palette_index
);

  localparam int Depth  = 7;
  localparam int Groups = npcm_pkg::PalSize / 4;

  logic [Depth-1:0] vld_r, vld_nxt;
  npcm_pkg::root_t  lane_dist [npcm_pkg::PalSize];

  npcm_pkg::root_t  grp_root_r [Groups];
  npcm_pkg::idx_t   grp_idx_r  [Groups];
  npcm_pkg::root_t  grp_root_nxt [Groups];
  npcm_pkg::idx_t   grp_idx_nxt  [Groups];

  npcm_pkg::root_t  best_root_r, best_root_nxt;
  npcm_pkg::idx_t   best_idx_r, best_idx_nxt;

  assign busy = 1'b0;

  for (genvar i = 0; i < npcm_pkg::PalSize; i++) begin : g_lane
    npcm_lane u_lane (
      .clk       (clk),
      .px_red    (in_red),
      .px_green  (in_green),
      .px_blue   (in_blue),
      .pal       (npcm_pkg::pal_color(npcm_pkg::idx_t'(i))),
      .dist_root (lane_dist[i])
    );
  end

  assign vld_nxt = {vld_r[Depth-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // groups of four: pair winners, then left pair kept on a tie
  // entry 1 beats entry 0 on a tie since the search starts from it
  always_comb begin
    npcm_pkg::root_t pr [2];
    npcm_pkg::idx_t  pi [2];
    for (int g = 0; g < Groups; g++) begin
      for (int p = 0; p < 2; p++) begin
        if ((lane_dist[4*g+2*p+1] < lane_dist[4*g+2*p]) ||
            ((g == 0) && (p == 0) && (lane_dist[1] == lane_dist[0]))) begin
          pr[p] = lane_dist[4*g+2*p+1];
          pi[p] = npcm_pkg::idx_t'(4*g+2*p+1);
        end else begin
          pr[p] = lane_dist[4*g+2*p];
          pi[p] = npcm_pkg::idx_t'(4*g+2*p);
        end
      end
      if (pr[1] < pr[0]) begin
        grp_root_nxt[g] = pr[1];
        grp_idx_nxt[g]  = pi[1];
      end else begin
        grp_root_nxt[g] = pr[0];
        grp_idx_nxt[g]  = pi[0];
      end
    end
  end

  always_comb begin
    best_root_nxt = grp_root_r[0];
    best_idx_nxt  = grp_idx_r[0];
    for (int g = 1; g < Groups; g++) begin
      if (grp_root_r[g] < best_root_nxt) begin
        best_root_nxt = grp_root_r[g];
        best_idx_nxt  = grp_idx_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < Groups; g++) begin
      grp_root_r[g] <= grp_root_nxt[g];
      grp_idx_r[g]  <= grp_idx_nxt[g];
    end
    best_root_r <= best_root_nxt;
    best_idx_r  <= best_idx_nxt;
  end

  assign out_valid         = vld_r[Depth-1];
  assign out_palette_index = best_idx_r;

  // a result word always follows an earlier pixel
  a_result_follows_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Depth))
    else $error("result word without a matching pixel");

  // entry 8 duplicates entry 0 and can never win
  a_no_duplicate_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_palette_index != npcm_pkg::idx_t'(8)))
    else $error("duplicate black entry selected");

  // the winner is never farther than the starting candidate
  a_not_worse_than_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (best_root_r <= $past(lane_dist[1], 2)))
    else $error("winner farther than entry 1");

endmodule

[test/nearest_palette_color_match_checker.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_match_checker
// Watches the pixel and result channels of the nearest palette color match
// core. Each accepted pixel is scored against its own copy of the sixteen
// color palette, and the predicted index is queued. Every result word is then
// compared in order with the oldest queued index. Mismatches are counted and
// handed to the testbench top together with the number of open predictions.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  npcm_pkg::chan_t      in_red,
  input  npcm_pkg::chan_t      in_green,
  input  npcm_pkg::chan_t      in_blue,
  input  logic                 out_valid,
  input  npcm_pkg::idx_t       out_palette_index,
  output int unsigned          fail_count,
  output int unsigned          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // entry 0 in the low 24 bits, each entry packed as r, g, b
  localparam logic [16*24-1:0] PALETTE = {
    24'hFFFFFF, 24'hFFFF00, 24'hFFCCFF, 24'hFF6666,
    24'h00FF64, 24'h66FF66, 24'h6666FF, 24'h000000,
    24'h7F7F7F, 24'hCC9966, 24'hFF7FFF, 24'hB20000,
    24'h00B2B2, 24'h00B200, 24'h0000B2, 24'h000000
  };

  typedef struct {
    npcm_pkg::rgb_t pixel;
    npcm_pkg::idx_t index;
  } match_t;

  match_t      expected_match_q[$];
  int unsigned mismatches = 0;

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 9; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned color_distance(input int i, input npcm_pkg::rgb_t p);
    logic [23:0] c;
    int          dr;
    int          dg;
    int          db;
    c  = PALETTE[i*24 +: 24];
    dr = int'(c[23:16]) - int'(p.r);
    dg = int'(c[15:8]) - int'(p.g);
    db = int'(c[7:0]) - int'(p.b);
    return floor_root(dr * dr + dg * dg + db * db);
  endfunction

  // entry 1 starts as the best, only a strictly nearer entry replaces it
  function automatic npcm_pkg::idx_t nearest_entry(input npcm_pkg::rgb_t p);
    int unsigned    best;
    int unsigned    d;
    npcm_pkg::idx_t best_idx;
    best_idx = 4'd1;
    best     = color_distance(1, p);
    for (int i = 0; i < npcm_pkg::PalSize; i++) begin
      d = color_distance(i, p);
      if (d < best) begin
        best     = d;
        best_idx = npcm_pkg::idx_t'(i);
      end
    end
    return best_idx;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] palette match error: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    match_t m;
    if (rst_n) begin
      if (start && !busy) begin
        m.pixel = '{in_red, in_green, in_blue};
        m.index = nearest_entry(m.pixel);
        expected_match_q.push_back(m);
      end
      if (out_valid) begin
        if (expected_match_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word, index %0d", out_palette_index));
        end else begin
          m = expected_match_q.pop_front();
          if (out_palette_index !== m.index)
            report_mismatch($sformatf("pixel %0d,%0d,%0d: index %0d, expected %0d",
                                      m.pixel.r, m.pixel.g, m.pixel.b,
                                      out_palette_index, m.index));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_match_q.size();
  end

endmodule

[test/nearest_palette_color_match_core_tb.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core_tb
// Drives pixels into the nearest palette color match core: the palette
// colors themselves, tie points and channel extremes first, then random
// pixels that are uniform, close to a palette entry, close to the midpoint
// of two entries, or built from channel extremes. Checking is done by the
// checker instance; a watchdog ends the run when the channels go quiet.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS  = 1850;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum int {
    PIX_UNIFORM,
    PIX_NEAR_ENTRY,
    PIX_MIDPOINT,
    PIX_CORNER
  } pix_kind_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  npcm_pkg::chan_t in_red;
  npcm_pkg::chan_t in_green;
  npcm_pkg::chan_t in_blue;
  logic            out_valid;
  npcm_pkg::idx_t  out_palette_index;
  int unsigned     fail_count;
  int unsigned     pending;
  int              idle_pct = 14;
  int              quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nearest_palette_color_match_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_palette_index (out_palette_index)
  );

  nearest_palette_color_match_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_palette_index (out_palette_index),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic npcm_pkg::chan_t clamp_chan(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return npcm_pkg::chan_t'(v);
  endfunction

  function automatic npcm_pkg::chan_t jitter_chan(input int v, input int span);
    return clamp_chan(v + int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic npcm_pkg::chan_t corner_chan();
    case ($urandom_range(2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return npcm_pkg::chan_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input npcm_pkg::chan_t r, input npcm_pkg::chan_t g,
                            input npcm_pkg::chan_t b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      in_red   <= npcm_pkg::chan_t'($urandom);
      in_green <= npcm_pkg::chan_t'($urandom);
      in_blue  <= npcm_pkg::chan_t'($urandom);
      @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    npcm_pkg::rgb_t a;
    npcm_pkg::rgb_t c;
    pix_kind_t      kind;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_red   <= '0;
    in_green <= '0;
    in_blue  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every palette color, then tie points and extremes
    for (int i = 0; i < npcm_pkg::PalSize; i++) begin
      a = npcm_pkg::pal_color(npcm_pkg::idx_t'(i));
      send_pixel(a.r, a.g, a.b);
    end
    send_pixel(8'd0, 8'd0, 8'd89);
    send_pixel(8'd0, 8'd89, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd90);
    send_pixel(8'd255, 8'd255, 8'd127);
    send_pixel(8'd255, 8'd255, 8'd128);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd51, 8'd51, 8'd51);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      idle_pct = (n >= 600 && n < 1000) ? 0 : 14;
      kind = pix_kind_t'($urandom_range(3));
      case (kind)
        PIX_NEAR_ENTRY: begin
          a = npcm_pkg::pal_color(npcm_pkg::idx_t'($urandom_range(15)));
          send_pixel(jitter_chan(a.r, 12), jitter_chan(a.g, 12), jitter_chan(a.b, 12));
        end
        PIX_MIDPOINT: begin
          a = npcm_pkg::pal_color(npcm_pkg::idx_t'($urandom_range(15)));
          c = npcm_pkg::pal_color(npcm_pkg::idx_t'($urandom_range(15)));
          send_pixel(jitter_chan((int'(a.r) + int'(c.r)) / 2, 3),
                     jitter_chan((int'(a.g) + int'(c.g)) / 2, 3),
                     jitter_chan((int'(a.b) + int'(c.b)) / 2, 3));
        end
        PIX_CORNER: begin
          send_pixel(corner_chan(), corner_chan(), corner_chan());
        end
        default: begin
          send_pixel(npcm_pkg::chan_t'($urandom), npcm_pkg::chan_t'($urandom),
                     npcm_pkg::chan_t'($urandom));
        end
      endcase
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_lane.sv
hw/rtl/nearest_palette_color_match_core.sv
test/nearest_palette_color_match_checker.sv
test/nearest_palette_color_match_core_tb.sv
